FILE: rtl/core/pfc_pkg.sv
// pfc_pkg: shared types and constants of the page flash command controller
// no dependencies
`default_nettype none
package pfc_pkg;

  localparam int ADDR_W = 19;
  localparam int PAGE_W = 8;
  localparam int CNT_W  = 16;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ARMED = 2'd1;
  localparam logic [1:0] PH_LOAD  = 2'd2;
  localparam logic [1:0] PH_BURN  = 2'd3;

  localparam logic [ADDR_W-1:0] UNLOCK_ADDR_A = 19'h05555;
  localparam logic [ADDR_W-1:0] UNLOCK_ADDR_B = 19'h02aaa;
  localparam logic [ADDR_W-1:0] UPPER_ID_ADDR = 19'h7fff2;
  localparam logic [7:0] UNLOCK_DATA_A = 8'haa;
  localparam logic [7:0] UNLOCK_DATA_B = 8'h55;
  localparam logic [7:0] MFR_ID        = 8'h1f;
  localparam logic [7:0] DEV_ID        = 8'ha4;

  localparam logic [7:0] CMD_ERASE    = 8'h10;
  localparam logic [7:0] CMD_PROT_OFF = 8'h20;
  localparam logic [7:0] CMD_LOCKOUT  = 8'h40;
  localparam logic [7:0] CMD_PREFIX   = 8'h80;
  localparam logic [7:0] CMD_ID_ENTER = 8'h90;
  localparam logic [7:0] CMD_PROT_ON  = 8'ha0;
  localparam logic [7:0] CMD_ID_EXIT  = 8'hf0;

  typedef struct packed {
    logic [1:0]        unlock_step;
    logic              prefix_seen;
    logic [1:0]        phase;
    logic              lockout_pend;
    logic              prot_on_pend;
    logic              prot_off_pend;
    logic              lower_lock;
    logic              upper_lock;
    logic              write_protect;
    logic              ident_mode;
    logic              toggle;
    logic [ADDR_W-1:0] last_addr;
    logic              last_bit0;
    logic [CNT_W-1:0]  countdown;
    logic              armed;
    logic              changed;
  } pfc_state_t;

  typedef struct packed {
    logic       read_array;
    logic       commit;
    logic       erase;
    logic       buf_clear;
    logic       buf_write;
  } pfc_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/core/pfc_step.sv
// pfc_step: next-state logic of the command controller for one item
// depends on pfc_pkg
`default_nettype none
module pfc_step import pfc_pkg::*; #(
  parameter int BOOT_BLOCK_BYTES = 16384
) (
  input  wire pfc_state_t        cur,
  input  wire logic [1:0]        action,
  input  wire logic [ADDR_W-1:0] address,
  input  wire logic [7:0]        write_byte,
  input  wire logic [CNT_W-1:0]  load_window_ticks,
  input  wire logic [CNT_W-1:0]  burn_ticks,
  output pfc_state_t             nxt,
  output pfc_ctrl_t              ctrl,
  output logic [7:0]             reply
);

  localparam logic [ADDR_W-1:0] LOW_END  = ADDR_W'(BOOT_BLOCK_BYTES);
  localparam logic [ADDR_W-1:0] HIGH_BEG = ADDR_W'((1 << ADDR_W) - BOOT_BLOCK_BYTES);

  logic done;

  always_comb begin
    nxt   = cur;
    ctrl  = '0;
    reply = 8'd0;
    done  = 1'b0;
    case (action)
      ACT_READ: begin
        nxt.unlock_step  = 2'd0;
        nxt.prefix_seen  = 1'b0;
        nxt.lockout_pend = 1'b0;
        if (cur.phase == PH_ARMED) begin
          nxt.phase = PH_IDLE; nxt.prot_on_pend = 1'b0; nxt.prot_off_pend = 1'b0;
          nxt.armed = 1'b0; nxt.countdown = '0;
        end
        if (cur.ident_mode) begin
          if (address == 19'd0) reply = MFR_ID;
          else if (address == 19'd1) reply = DEV_ID;
          else if (address == 19'd2) reply = {7'h7f, cur.lower_lock};
          else if (address == UPPER_ID_ADDR) reply = {7'h7f, cur.upper_lock};
        end else if (cur.phase == PH_LOAD || cur.phase == PH_BURN) begin
          if (cur.phase == PH_LOAD) begin
            nxt.phase = PH_BURN; nxt.countdown = burn_ticks; nxt.armed = 1'b1;
          end
          reply = {6'd0, cur.toggle, (address == cur.last_addr) && !cur.last_bit0};
          nxt.toggle = !cur.toggle;
        end else begin
          ctrl.read_array = 1'b1;
        end
      end
      ACT_WRITE: begin
        if (cur.lockout_pend) begin
          nxt.lockout_pend = 1'b0;
          if (address == 19'd0 && write_byte == 8'h00) begin
            nxt.lower_lock = 1'b1; nxt.changed = 1'b1; done = 1'b1;
          end else if (address == '1 && write_byte == 8'hff) begin
            nxt.upper_lock = 1'b1; nxt.changed = 1'b1; done = 1'b1;
          end
        end
        if (!done) begin
          if (cur.unlock_step == 2'd0 && address == UNLOCK_ADDR_A &&
              write_byte == UNLOCK_DATA_A) begin
            nxt.unlock_step = 2'd1;
          end else if (cur.unlock_step == 2'd1 && address == UNLOCK_ADDR_B &&
                       write_byte == UNLOCK_DATA_B) begin
            nxt.unlock_step = 2'd2;
          end else if (cur.unlock_step == 2'd2 && address == UNLOCK_ADDR_A) begin
            nxt.phase = PH_IDLE; nxt.prot_on_pend = 1'b0; nxt.prot_off_pend = 1'b0;
            nxt.armed = 1'b0; nxt.countdown = '0;
            case (write_byte)
              CMD_ERASE: begin
                if (cur.prefix_seen && !cur.lower_lock && !cur.upper_lock) begin
                  ctrl.erase = 1'b1; nxt.changed = 1'b1;
                end
              end
              CMD_PROT_OFF: begin
                if (cur.prefix_seen) begin
                  nxt.phase = PH_ARMED; nxt.prot_off_pend = 1'b1;
                end
              end
              CMD_LOCKOUT: begin
                if (cur.prefix_seen) nxt.lockout_pend = 1'b1;
              end
              CMD_ID_ENTER: nxt.ident_mode = 1'b1;
              CMD_PROT_ON: begin
                nxt.phase = PH_ARMED; nxt.prot_on_pend = 1'b1;
              end
              CMD_ID_EXIT: nxt.ident_mode = 1'b0;
              default: ;
            endcase
            nxt.unlock_step = 2'd0;
            nxt.prefix_seen = (write_byte == CMD_PREFIX);
            done = 1'b1;
          end else begin
            nxt.unlock_step = 2'd0;
            nxt.prefix_seen = 1'b0;
          end
        end
        if (!done) begin
          if (nxt.phase == PH_LOAD &&
              address[ADDR_W-1:PAGE_W] != cur.last_addr[ADDR_W-1:PAGE_W]) begin
            nxt.phase = PH_IDLE; nxt.prot_on_pend = 1'b0; nxt.prot_off_pend = 1'b0;
            nxt.armed = 1'b0; nxt.countdown = '0;
          end
          if ((nxt.phase == PH_IDLE && !nxt.write_protect) || nxt.phase == PH_ARMED) begin
            if ((address < LOW_END && nxt.lower_lock) ||
                (address >= HIGH_BEG && nxt.upper_lock)) begin
              nxt.phase = PH_IDLE; nxt.prot_on_pend = 1'b0; nxt.prot_off_pend = 1'b0;
              nxt.armed = 1'b0; nxt.countdown = '0;
            end else begin
              ctrl.buf_clear = 1'b1;
              nxt.phase = PH_LOAD;
            end
          end
          if (nxt.phase == PH_LOAD) begin
            ctrl.buf_write = 1'b1;
            nxt.last_addr  = address;
            nxt.last_bit0  = write_byte[0];
            nxt.countdown  = load_window_ticks;
            nxt.armed      = 1'b1;
          end
        end
      end
      ACT_TICK: begin
        if (cur.armed) begin
          if (cur.countdown <= 16'd1) begin
            nxt.countdown = '0;
            nxt.armed = 1'b0;
            case (cur.phase)
              PH_ARMED: nxt.phase = PH_IDLE;
              PH_LOAD: begin
                nxt.phase = PH_BURN; nxt.countdown = burn_ticks; nxt.armed = 1'b1;
              end
              PH_BURN: begin
                ctrl.commit = 1'b1;
                if (cur.prot_on_pend) nxt.write_protect = 1'b1;
                if (cur.prot_off_pend) nxt.write_protect = 1'b0;
                nxt.phase = PH_IDLE;
                nxt.prot_on_pend = 1'b0;
                nxt.prot_off_pend = 1'b0;
                nxt.changed = 1'b1;
              end
              default: ;
            endcase
          end else begin
            nxt.countdown = cur.countdown - 16'd1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/page_flash_command_controller_core.sv
// page_flash_command_controller_core: top level, flash array and page buffer memories
// depends on pfc_pkg and pfc_step
`default_nettype none
// One item is taken at a time. Ticks, writes and status or ID reads are answered
// directly; an array read passes through ST_READ for the registered memory read. A
// page commit walks the page buffer into the array, and a chip erase walks the whole
// array. After reset the array is cleared to all ones by the same pass as the erase,
// during which no item is accepted; register writes are always taken.
module page_flash_command_controller_core import pfc_pkg::*; #(
  parameter int BOOT_BLOCK_BYTES = 16384
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic              cfg_index,
  input  wire logic [15:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        action,
  input  wire logic [ADDR_W-1:0] address,
  input  wire logic [7:0]        write_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             read_byte,
  output logic                   contents_changed,
  output logic                   burning
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_COMMIT = 3'd3;

  logic [2:0]          state;
  logic [ADDR_W-1:0]   sweep;
  logic [PAGE_W:0]     ccnt;
  logic [CNT_W-1:0]    load_window_ticks;
  logic [CNT_W-1:0]    burn_ticks;
  pfc_state_t          cur;
  pfc_state_t          nxt;
  pfc_state_t          cur_init;
  pfc_ctrl_t           ctrl;
  logic [7:0]          reply;
  logic                accept;
  logic                out_set;
  logic [7:0]          flash_mem [0:(1<<ADDR_W)-1];
  logic [7:0]          pbuf [0:(1<<PAGE_W)-1];
  logic [(1<<PAGE_W)-1:0] pvld;
  logic [(1<<PAGE_W)-1:0] pvld_one;
  logic [7:0]          flash_q;
  logic [7:0]          pbuf_q;
  logic                pvld_q;
  logic                fl_we;
  logic [ADDR_W-1:0]   fl_wa;
  logic [7:0]          fl_wd;
  logic [ADDR_W-PAGE_W-1:0] cpage;

  pfc_step #(.BOOT_BLOCK_BYTES(BOOT_BLOCK_BYTES)) u_step (
    .cur(cur), .action(action), .address(address), .write_byte(write_byte),
    .load_window_ticks(load_window_ticks), .burn_ticks(burn_ticks),
    .nxt(nxt), .ctrl(ctrl), .reply(reply)
  );

  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign out_set  = (state == ST_READ) || (accept && !ctrl.read_array);
  assign pvld_one = {{((1<<PAGE_W)-1){1'b0}}, 1'b1} << address[PAGE_W-1:0];

  always_comb begin
    cur_init = '0;
    cur_init.last_bit0 = 1'b1;
  end

  always_comb begin
    fl_we = 1'b0;
    fl_wa = sweep;
    fl_wd = 8'hff;
    if (state == ST_CLEAR) begin
      fl_we = 1'b1;
    end else if (state == ST_COMMIT && ccnt != '0) begin
      fl_we = 1'b1;
      fl_wa = {cpage, 8'(ccnt - 9'd1)};
      fl_wd = pvld_q ? pbuf_q : 8'hff;
    end
  end

  always_ff @(posedge clk) begin
    if (fl_we) flash_mem[fl_wa] <= fl_wd;
    flash_q <= flash_mem[address];
  end

  always_ff @(posedge clk) begin
    if (accept && ctrl.buf_write) pbuf[address[PAGE_W-1:0]] <= write_byte;
    pbuf_q <= pbuf[ccnt[PAGE_W-1:0]];
    pvld_q <= pvld[ccnt[PAGE_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_window_ticks <= 16'd150;
      burn_ticks        <= 16'd5000;
    end else if (cfg_write) begin
      if (cfg_index) burn_ticks <= cfg_data;
      else load_window_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep     <= '0;
      ccnt      <= '0;
      cur       <= cur_init;
      pvld      <= '0;
      out_valid <= 1'b0;
      cpage     <= '0;
    end else begin
      if (out_set) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          sweep <= sweep + 19'd1;
          if (sweep == '1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            cur <= nxt;
            contents_changed <= nxt.changed;
            burning <= (nxt.phase == PH_LOAD) || (nxt.phase == PH_BURN);
            read_byte <= reply;
            if (ctrl.buf_write) pvld <= (ctrl.buf_clear ? '0 : pvld) | pvld_one;
            if (ctrl.read_array) begin
              state <= ST_READ;
            end else begin
              if (ctrl.commit) begin
                state <= ST_COMMIT;
                ccnt  <= '0;
                cpage <= cur.last_addr[ADDR_W-1:PAGE_W];
              end else if (ctrl.erase) begin
                state <= ST_CLEAR;
                sweep <= '0;
              end
            end
          end
        end
        ST_READ: begin
          read_byte <= flash_q;
          state     <= ST_IDLE;
        end
        ST_COMMIT: begin
          ccnt <= ccnt + 9'd1;
          if (ccnt == 9'(1 << PAGE_W)) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sim/tb.sv
// tb: self-checking testbench of page_flash_command_controller_core
// depends on pfc_pkg and the core; predicts each reply and compares it in order
`timescale 1ns / 1ps
module tb;
  import pfc_pkg::*;

  localparam int BOOT_BYTES = 16384;
  localparam int WATCHDOG_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 600;
  localparam logic [ADDR_W-1:0] TOP_ADDR = 19'h7ffff;

  typedef struct packed {
    logic [7:0] rb;
    logic       chg;
    logic       brn;
  } reply_t;

  class flash_scoreboard;
    reply_t expected_q[$];
    int errors = 0;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note(reply_t r);
      expected_q.push_back(r);
    endfunction

    task check(reply_t got);
      reply_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected reply %h", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.rb !== want.rb)
        report($sformatf("read_byte %h, want %h", got.rb, want.rb));
      if (got.chg !== want.chg)
        report($sformatf("contents_changed %b, want %b", got.chg, want.chg));
      if (got.brn !== want.brn)
        report($sformatf("burning %b, want %b", got.brn, want.brn));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic cfg_index = 0;
  logic [15:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] action = 0;
  logic [ADDR_W-1:0] address = 0;
  logic [7:0] write_byte = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [7:0] read_byte;
  logic contents_changed;
  logic burning;

  page_flash_command_controller_core #(.BOOT_BLOCK_BYTES(BOOT_BYTES)) dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .address(address),
    .write_byte(write_byte), .out_valid(out_valid), .out_stall(out_stall),
    .read_byte(read_byte), .contents_changed(contents_changed), .burning(burning)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  flash_scoreboard sb = new();

  // flash model state
  logic [15:0] m_load, m_burn;
  logic [7:0] m_flash [int];
  logic [7:0] m_page [256];
  logic [1:0] m_step, m_phase;
  logic m_prefix, m_lock_arg, m_pon, m_poff, m_lower, m_upper, m_wp, m_ident, m_toggle;
  logic m_armed, m_changed;
  logic [ADDR_W-1:0] m_last;
  logic [15:0] m_count;

  function automatic void mdl_reset();
    m_load = 16'd150;
    m_burn = 16'd5000;
    m_flash.delete();
    foreach (m_page[i]) m_page[i] = 8'hff;
    m_step = 0; m_prefix = 0; m_phase = PH_IDLE; m_lock_arg = 0; m_pon = 0; m_poff = 0;
    m_lower = 0; m_upper = 0; m_wp = 0; m_ident = 0; m_toggle = 0; m_last = 0;
    m_count = 0; m_armed = 0; m_changed = 0;
  endfunction

  function automatic void mdl_arm(logic [15:0] t);
    m_count = t;
    m_armed = 1;
  endfunction

  function automatic void mdl_cancel();
    m_phase = PH_IDLE; m_pon = 0; m_poff = 0; m_armed = 0; m_count = 0;
  endfunction

  function automatic void mdl_expire();
    int base;
    if (m_phase == PH_ARMED) begin
      m_phase = PH_IDLE;
    end else if (m_phase == PH_LOAD) begin
      m_phase = PH_BURN;
      mdl_arm(m_burn);
    end else if (m_phase == PH_BURN) begin
      base = int'(m_last) & ~255;
      for (int i = 0; i < 256; i++) m_flash[base + i] = m_page[i];
      if (m_pon) m_wp = 1;
      if (m_poff) m_wp = 0;
      m_phase = PH_IDLE; m_pon = 0; m_poff = 0; m_changed = 1;
    end
  endfunction

  function automatic logic [7:0] mdl_read(logic [ADDR_W-1:0] a);
    logic [7:0] r;
    m_step = 0; m_prefix = 0; m_lock_arg = 0;
    if (m_phase == PH_ARMED) mdl_cancel();
    if (m_ident) begin
      if (a == 0) r = MFR_ID;
      else if (a == 1) r = DEV_ID;
      else if (a == 2) r = m_lower ? 8'hff : 8'hfe;
      else if (a == UPPER_ID_ADDR) r = m_upper ? 8'hff : 8'hfe;
      else r = 0;
    end else if (m_phase == PH_LOAD || m_phase == PH_BURN) begin
      if (m_phase == PH_LOAD) begin
        m_phase = PH_BURN;
        mdl_arm(m_burn);
      end
      r = m_toggle ? 8'h02 : 8'h00;
      m_toggle = ~m_toggle;
      if (a == m_last && m_page[m_last[7:0]][0] == 1'b0) r[0] = 1'b1;
    end else begin
      r = m_flash.exists(int'(a)) ? m_flash[int'(a)] : 8'hff;
    end
    return r;
  endfunction

  function automatic void mdl_command(logic [7:0] d);
    mdl_cancel();
    case (d)
      CMD_ERASE: begin
        if (m_prefix && !m_lower && !m_upper) begin
          m_flash.delete();
          m_changed = 1;
        end
      end
      CMD_PROT_OFF: begin
        if (m_prefix) begin
          m_phase = PH_ARMED;
          m_poff = 1;
        end
      end
      CMD_LOCKOUT: begin
        if (m_prefix) m_lock_arg = 1;
      end
      CMD_ID_ENTER: m_ident = 1;
      CMD_PROT_ON: begin
        m_phase = PH_ARMED;
        m_pon = 1;
      end
      CMD_ID_EXIT: m_ident = 0;
      default: ;
    endcase
    m_step = 0;
    m_prefix = (d == CMD_PREFIX);
  endfunction

  function automatic void mdl_write(logic [ADDR_W-1:0] a, logic [7:0] d);
    if (m_lock_arg) begin
      m_lock_arg = 0;
      if (a == 0 && d == 8'h00) begin
        m_lower = 1; m_changed = 1;
        return;
      end
      if (a == TOP_ADDR && d == 8'hff) begin
        m_upper = 1; m_changed = 1;
        return;
      end
    end
    if (m_step == 0 && a == UNLOCK_ADDR_A && d == UNLOCK_DATA_A) begin
      m_step = 1;
    end else if (m_step == 1 && a == UNLOCK_ADDR_B && d == UNLOCK_DATA_B) begin
      m_step = 2;
    end else if (m_step == 2 && a == UNLOCK_ADDR_A) begin
      mdl_command(d);
      return;
    end else begin
      m_step = 0; m_prefix = 0;
    end
    if (m_phase == PH_LOAD && a[18:8] != m_last[18:8]) mdl_cancel();
    if ((m_phase == PH_IDLE && !m_wp) || m_phase == PH_ARMED) begin
      if ((int'(a) < BOOT_BYTES && m_lower) ||
          (int'(a) >= 524288 - BOOT_BYTES && m_upper)) begin
        mdl_cancel();
      end else begin
        foreach (m_page[i]) m_page[i] = 8'hff;
        m_phase = PH_LOAD;
      end
    end
    if (m_phase == PH_LOAD) begin
      m_page[a[7:0]] = d;
      m_last = a;
      mdl_arm(m_load);
    end
  endfunction

  function automatic void mdl_tick();
    if (!m_armed) return;
    if (m_count <= 1) begin
      m_count = 0; m_armed = 0;
      mdl_expire();
    end else begin
      m_count--;
    end
  endfunction

  function automatic reply_t mdl_step(logic [1:0] act, logic [ADDR_W-1:0] a, logic [7:0] d);
    reply_t r;
    r.rb = 0;
    if (act == ACT_READ) r.rb = mdl_read(a);
    else if (act == ACT_WRITE) mdl_write(a, d);
    else if (act == ACT_TICK) mdl_tick();
    r.chg = m_changed;
    r.brn = (m_phase == PH_LOAD || m_phase == PH_BURN);
    return r;
  endfunction

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check({read_byte, contents_changed, burning});
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(logic [1:0] act, logic [ADDR_W-1:0] a, logic [7:0] d);
    in_valid <= 1;
    action <= act;
    address <= a;
    write_byte <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(mdl_step(act, a, d));
    items_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic unlock_cmd(logic [7:0] cmd);
    send(ACT_WRITE, UNLOCK_ADDR_A, UNLOCK_DATA_A);
    send(ACT_WRITE, UNLOCK_ADDR_B, UNLOCK_DATA_B);
    send(ACT_WRITE, UNLOCK_ADDR_A, cmd);
  endtask

  task automatic ticks(int n);
    repeat (n) send(ACT_TICK, ADDR_W'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [15:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    if (idx == 0) m_load = val;
    else m_burn = val;
  endtask

  task automatic page_load();
    logic [ADDR_W-1:0] base;
    int n;
    base = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 19'h0 : 19'h7ff00)
                                     : ADDR_W'($urandom);
    base[7:0] = 0;
    n = $urandom_range(1, 6);
    repeat (n) send(ACT_WRITE, base | ADDR_W'($urandom_range(0, 255)), 8'($urandom));
    if ($urandom_range(0, 2) == 0) send(ACT_READ, m_last, 8'h00);
    ticks($urandom_range(0, 3) + ((m_load + m_burn > 24) ? 12 : int'(m_load + m_burn)));
  endtask

  task automatic random_part(int count);
    int target;
    logic [7:0] cmd;
    target = items_sent + count;
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          case ($urandom_range(0, 6))
            0: cmd = CMD_PROT_OFF;
            1: cmd = CMD_LOCKOUT;
            2: cmd = CMD_ID_ENTER;
            3: cmd = CMD_PROT_ON;
            4: cmd = CMD_ID_EXIT;
            5: cmd = CMD_PREFIX;
            default: cmd = 8'($urandom);
          endcase
          if (cmd == CMD_ERASE) cmd = CMD_ID_EXIT;
          if ($urandom_range(0, 1)) unlock_cmd(CMD_PREFIX);
          unlock_cmd(cmd);
          if (cmd == CMD_LOCKOUT && $urandom_range(0, 3) == 0)
            send(ACT_WRITE, $urandom_range(0, 1) ? 19'h0 : TOP_ADDR,
                 $urandom_range(0, 1) ? 8'h00 : 8'hff);
          if (cmd == CMD_PROT_ON || cmd == CMD_PROT_OFF) page_load();
        end
        2, 3, 4: page_load();
        5, 6: begin
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 3))
              0: send(ACT_READ, m_last, 8'h00);
              1: send(ACT_READ, ADDR_W'($urandom_range(0, 2)), 8'h00);
              2: send(ACT_READ, UPPER_ID_ADDR, 8'h00);
              default: send(ACT_READ, ADDR_W'($urandom), 8'h00);
            endcase
          end
        end
        7: ticks($urandom_range(1, 5));
        8: begin
          send(ACT_WRITE, UNLOCK_ADDR_A, UNLOCK_DATA_A);
          if ($urandom_range(0, 1)) send(ACT_WRITE, UNLOCK_ADDR_B, UNLOCK_DATA_B);
          send($urandom_range(0, 1) ? ACT_READ : ACT_WRITE, ADDR_W'($urandom), 8'($urandom));
        end
        default: send(2'($urandom_range(0, 3)), ADDR_W'($urandom), 8'($urandom));
      endcase
    end
  endtask

  task automatic directed();
    send(ACT_READ, 19'h0, 8'h00);
    send(ACT_READ, TOP_ADDR, 8'h00);
    send(2'd3, TOP_ADDR, 8'hff);
    send(ACT_WRITE, 19'h12345, 8'h00);
    send(ACT_READ, 19'h12345, 8'h00);
    ticks(3);
    send(ACT_READ, 19'h12345, 8'h00);
    unlock_cmd(CMD_ID_ENTER);
    send(ACT_READ, 19'h0, 8'h00);
    send(ACT_READ, 19'h1, 8'h00);
    send(ACT_READ, 19'h2, 8'h00);
    send(ACT_READ, UPPER_ID_ADDR, 8'h00);
    unlock_cmd(CMD_ID_EXIT);
    unlock_cmd(CMD_PREFIX);
    unlock_cmd(CMD_ERASE);
    drain();
    send(ACT_READ, 19'h12345, 8'h00);
    unlock_cmd(CMD_PREFIX);
    unlock_cmd(CMD_LOCKOUT);
    send(ACT_WRITE, 19'h0, 8'h00);
    unlock_cmd(CMD_PREFIX);
    unlock_cmd(CMD_LOCKOUT);
    send(ACT_WRITE, TOP_ADDR, 8'hff);
    unlock_cmd(CMD_PREFIX);
    unlock_cmd(CMD_ERASE);
    send(ACT_WRITE, 19'h00010, 8'h5a);
  endtask

  initial begin
    mdl_reset();
    repeat (2) @(posedge clk);
    rst <= 0;
    set_reg(0, 16'd2);
    set_reg(1, 16'd3);
    directed();
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      case (ph)
        0: begin set_reg(0, 16'd1); set_reg(1, 16'd1); end
        1: begin set_reg(0, 16'd0); set_reg(1, 16'd0); end
        2: begin set_reg(0, 16'd65535); set_reg(1, 16'd65535); end
        3: begin set_reg(0, 16'd3); set_reg(1, 16'd7); end
        default: begin
          set_reg(0, 16'($urandom_range(1, 6)));
          set_reg(1, 16'($urandom_range(1, 9)));
        end
      endcase
      random_part(ph == 2 ? 40 : 90);
      drain();
    end
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
